// ===== sv/apfp_pkg.sv =====
package apfp_pkg;

  // output format codes of the pixel_format register
  localparam logic [2:0] FMT_RGB444 = 3'd0;
  localparam logic [2:0] FMT_RGB565 = 3'd1;
  localparam logic [2:0] FMT_RGB666 = 3'd2;
  localparam logic [2:0] FMT_RGB888 = 3'd3;
  localparam logic [2:0] FMT_ARGB32 = 3'd4;

  localparam logic [2:0] FMT_RESET = FMT_ARGB32;

  // largest number of bytes one pixel gives
  localparam int unsigned MAX_BYTES = 4;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] byte_cnt_t;
  typedef logic [1:0] byte_idx_t;
  typedef logic [11:0] nibbles_t;

endpackage

// ===== sv/argb_pixel_format_packer_unit.sv =====
// ARGB pixel format packer
//
// Input channel (in_valid / in_ready): one 32-bit ARGB pixel per item plus
// a last_pixel flag that closes the image. Result channel (out_valid /
// out_ready): one byte per item, with out_run_end high on the last byte a
// pixel gives. cfg_wr_en writes pixel_format in the same cycle; write it
// only while the block is idle.
// An accepted pixel is held in the input register, then its bytes are
// loaded into the burst register once that is free, which puts the first
// byte on the outputs. The burst register is reloaded at the very edge
// its last byte is taken, so bytes can go out back to back while the
// receiver is ready, N per pixel, N being the bytes per pixel of the
// format (2 for rgb565, 3 for rgb666/rgb888, 4 for argb32, 1.5 average
// for rgb444); a held rgb444 first half gives no byte.
// Reset (rst_n low, synchronous) empties both registers, drops any held
// rgb444 half and sets the format to argb32 passthrough.
// When the receiver stalls, the current byte holds on the outputs; the input
// register takes pixels until one that gives bytes waits, then in_ready falls.
module argb_pixel_format_packer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_pixel_format,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_end
);

  import apfp_pkg::*;

  logic [2:0]  fmt_r;

  logic        in_vld_r;
  logic [31:0] pix_r;
  logic        last_r;

  nibbles_t    held_r;
  nibbles_t    held_nxt;
  logic        pend_r;
  logic        pend_nxt;

  logic        burst_vld_r;
  byte_t       bytes_r [MAX_BYTES];
  byte_t       bytes_nxt [MAX_BYTES];
  byte_cnt_t   cnt_r;
  byte_cnt_t   cnt_nxt;
  byte_idx_t   idx_r;

  logic        no_bytes;
  logic        last_taken;
  logic        burst_free;
  logic        load;

  byte_t       ch_b;
  byte_t       ch_g;
  byte_t       ch_r;
  byte_t       ch_a;
  nibbles_t    nib;

  // channel split of the registered pixel
  assign ch_b = pix_r[7:0];
  assign ch_g = pix_r[15:8];
  assign ch_r = pix_r[23:16];
  assign ch_a = pix_r[31:24];
  assign nib  = {ch_r[7:4], ch_g[7:4], ch_b[7:4]};

  // pack the registered pixel into its bytes
  always_comb begin
    bytes_nxt[0] = ch_b;
    bytes_nxt[1] = ch_g;
    bytes_nxt[2] = ch_r;
    bytes_nxt[3] = ch_a;
    cnt_nxt      = byte_cnt_t'(MAX_BYTES);
    no_bytes     = 1'b0;
    held_nxt     = '0;
    pend_nxt     = 1'b0;
    case (fmt_r)
      FMT_RGB444: begin
        cnt_nxt      = 3'd3;
        bytes_nxt[3] = '0;
        if (pend_r) begin
          bytes_nxt[0] = held_r[11:4];
          bytes_nxt[1] = {held_r[3:0], nib[11:8]};
          bytes_nxt[2] = nib[7:0];
        end else if (last_r) begin
          // odd final pixel, paired with zero nibbles
          bytes_nxt[0] = nib[11:4];
          bytes_nxt[1] = {nib[3:0], 4'h0};
          bytes_nxt[2] = '0;
        end else begin
          // first half of a pair is held, nothing goes out
          bytes_nxt[0] = '0;
          bytes_nxt[1] = '0;
          bytes_nxt[2] = '0;
          no_bytes     = 1'b1;
          held_nxt     = nib;
          pend_nxt     = 1'b1;
        end
      end
      FMT_RGB565: begin
        cnt_nxt      = 3'd2;
        bytes_nxt[0] = {ch_r[7:3], ch_g[7:5]};
        bytes_nxt[1] = {ch_g[4:2], ch_b[7:3]};
      end
      FMT_RGB666: begin
        cnt_nxt      = 3'd3;
        bytes_nxt[0] = {ch_r[7:2], 2'b00};
        bytes_nxt[1] = {ch_g[7:2], 2'b00};
        bytes_nxt[2] = {ch_b[7:2], 2'b00};
      end
      FMT_RGB888: begin
        cnt_nxt      = 3'd3;
        bytes_nxt[0] = ch_r;
        bytes_nxt[1] = ch_g;
        bytes_nxt[2] = ch_b;
      end
      default: begin
        cnt_nxt = byte_cnt_t'(MAX_BYTES);
      end
    endcase
  end

  // handshake between the two register stages
  assign last_taken = burst_vld_r && out_ready && out_run_end;
  assign burst_free = !burst_vld_r || last_taken;
  assign load       = in_vld_r && (no_bytes || burst_free);
  assign in_ready   = !in_vld_r || load;

  assign out_valid   = burst_vld_r;
  assign out_byte    = bytes_r[idx_r];
  assign out_run_end = ({1'b0, idx_r} == (cnt_r - 3'd1));

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_pixel_format;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r  <= in_pixel;
      last_r <= in_last_pixel;
    end
  end

  // held rgb444 half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pend_r <= 1'b0;
    end else if (load) begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

  // burst register and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_vld_r <= 1'b0;
      idx_r       <= '0;
    end else if (load && !no_bytes) begin
      burst_vld_r <= 1'b1;
      idx_r       <= '0;
    end else if (last_taken) begin
      burst_vld_r <= 1'b0;
      idx_r       <= '0;
    end else if (burst_vld_r && out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !no_bytes) begin
      bytes_r <= bytes_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    burst_vld_r |-> ({1'b0, idx_r} < cnt_r))
    else $error("byte index beyond burst length");

  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> (held_r == '0))
    else $error("held nibbles set with no half pending");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && burst_vld_r))
    else $error("input stalled with a free stage");

  a_burst_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_run_end) |=> (!burst_vld_r || idx_r == '0))
    else $error("new burst does not start at its first byte");

endmodule
